// File: hw/rtl/color_space_pixel_threshold_defines.svh
// assertion macros used by the checker file
`ifndef COLOR_SPACE_PIXEL_THRESHOLD_DEFINES_SVH
`define COLOR_SPACE_PIXEL_THRESHOLD_DEFINES_SVH

// property checked on every rising edge, skipped while reset is high
`define CSPT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cspt check failed");

// property checked on every rising edge, reset included
`define CSPT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cspt check failed");

`endif

// File: hw/rtl/cspt_pkg.sv
// shared types, constants and helpers for the color space pixel threshold
package cspt_pkg;

   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REG_W       = 24;

   localparam int unsigned DIV_NUM_W   = 16;
   localparam int unsigned DIV_DEN_W   = 8;
   localparam int unsigned DIV_QUO_W   = 8;

   localparam logic [7:0]  HUE_STEP    = 8'd43;
   localparam logic [7:0]  HUE_GREEN   = 8'd85;
   localparam logic [7:0]  HUE_BLUE    = 8'd171;
   localparam logic [7:0]  FULL_SCALE  = 8'd255;
   localparam logic [9:0]  THIRD_MUL   = 10'd683;
   localparam int unsigned THIRD_SHIFT = 11;

   localparam logic [REG_W-1:0] LOW_RESET    = 24'h800000;
   localparam logic [REG_W-1:0] HIGH_RESET   = 24'hFFFFFF;
   localparam logic [REG_W-1:0] OUTSIDE_RESET = 24'h000000;
   localparam logic [REG_W-1:0] INSIDE_RESET = 24'h0000FF;

   typedef enum logic [1:0] {
      SPACE_RGB = 2'd0,
      SPACE_HSV = 2'd1,
      SPACE_HSL = 2'd2,
      SPACE_HSI = 2'd3
   } space_type;

   typedef enum logic [2:0] {
      REG_LOW     = 3'd0,
      REG_HIGH    = 3'd1,
      REG_OUTSIDE = 3'd2,
      REG_INSIDE  = 3'd3,
      REG_SPACE   = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       in_range;
   } result_type;

   // 255 * v by shift and subtract
   function automatic logic [15:0] mul255(input logic [7:0] v);
      return {v, 8'h00} - {8'h00, v};
   endfunction

endpackage

// File: hw/rtl/cspt_divider.sv
// pipelined restoring divider, one quotient bit per stage
module cspt_divider #(
   parameter int unsigned NUM_W = cspt_pkg::DIV_NUM_W,
   parameter int unsigned DEN_W = cspt_pkg::DIV_DEN_W,
   parameter int unsigned QUO_W = cspt_pkg::DIV_QUO_W
) (
   input  logic             clock,
   input  logic [QUO_W-1:0] step_en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int unsigned CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [CMP_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [CMP_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      logic [CMP_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [CMP_W-1:0] trial;
      for (int j = 0; j < QUO_W; j++) begin
         if (j == 0) begin
            rem_src = CMP_W'(num);
            den_src = den;
            quo_src = '0;
         end else begin
            rem_src = rem_ff[j-1];
            den_src = den_ff[j-1];
            quo_src = quo_ff[j-1];
         end
         trial = CMP_W'(den_src) << (QUO_W - 1 - j);
         rem_in[j] = rem_src;
         quo_in[j] = quo_src;
         if (rem_src >= trial) begin
            rem_in[j] = rem_src - trial;
            quo_in[j][QUO_W-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUO_W; j++) begin
         if (step_en[j]) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= (j == 0) ? den : den_ff[j-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// File: hw/rtl/color_space_pixel_threshold.sv
// color space pixel threshold: rgb pixel to rgb/hsv/hsl/hsi, bound check, color replace
// One pixel per clock sustained while the result side does not stall; an accepted request passes
// through the input register, min/max stage, setup stage, an 8-stage divider that yields one
// quotient bit per stage for hue and saturation, hue/saturation assembly, and the
// compare-and-select output register. Stalls on the result side ripple back stage by
// stage, so empty stages keep filling and a request is taken whenever any bubble exists.
// Hue is on a 0..255 circle (red 0, green 85, blue 171, 43 steps per chroma, truncating);
// grey pixels get hue and saturation 0; the hue window wraps when its low >= high.
// Registers on the apb port at 4*index: low bounds, high bounds, outside color, inside
// color, color space (0 rgb, 1 hsv, 2 hsl, 3 hsi). Channel packing is ch0 in 7:0,
// ch1 in 15:8, ch2 in 23:16; colors are red 7:0, green 15:8, blue 23:16.
// Write registers only while the pipeline is empty.
module color_space_pixel_threshold (
   input  logic                           clock,
   input  logic                           reset,
   // pixel requests
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cspt_pkg::pixel_type            req_data,
   // results
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cspt_pkg::result_type           rsp_data,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cspt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cspt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cspt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int unsigned QW     = cspt_pkg::DIV_QUO_W;
   localparam int unsigned ST_S0  = 0;
   localparam int unsigned ST_S1  = 1;
   localparam int unsigned ST_S2  = 2;
   localparam int unsigned ST_DIV = 3;
   localparam int unsigned ST_F1  = ST_DIV + QW;
   localparam int unsigned ST_F2  = ST_F1 + 1;
   localparam int unsigned NST    = ST_F2 + 1;

   // stage 1: max/min, hue sector, signed difference, channel sum
   typedef struct packed {
      cspt_pkg::pixel_type  pix;
      logic [7:0]           mx;
      logic [7:0]           mn;
      cspt_pkg::sector_type sector;
      logic                 neg;
      logic [7:0]           adiff;
      logic [9:0]           sum;
   } s1_type;

   // values that ride alongside the divider
   typedef struct packed {
      logic [7:0]           byp0;
      logic [7:0]           byp1;
      logic [7:0]           c2;
      cspt_pkg::sector_type sector;
      logic                 neg;
      logic                 grey;
      logic                 sat_full;
      logic                 sat_inv;
      logic                 rgb;
   } side_type;

   // stage 2: divider operands plus sideband
   typedef struct packed {
      logic [15:0] hue_num;
      logic [7:0]  hue_den;
      logic [15:0] sat_num;
      logic [7:0]  sat_den;
      side_type    side;
   } s2_type;

   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
   } f1_type;

   // ---------------------------------------------------------------- registers
   logic [cspt_pkg::REG_W-1:0] low_ff, high_ff, outside_ff, inside_ff;
   cspt_pkg::space_type        space_ff;
   logic                       wr_en;
   cspt_pkg::reg_idx_type      wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign wr_idx = cspt_pkg::reg_idx_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= cspt_pkg::LOW_RESET;
         high_ff    <= cspt_pkg::HIGH_RESET;
         outside_ff <= cspt_pkg::OUTSIDE_RESET;
         inside_ff  <= cspt_pkg::INSIDE_RESET;
         space_ff   <= cspt_pkg::SPACE_HSL;
      end else if (wr_en) begin
         case (wr_idx)
            cspt_pkg::REG_LOW:     low_ff     <= pwdata[cspt_pkg::REG_W-1:0];
            cspt_pkg::REG_HIGH:    high_ff    <= pwdata[cspt_pkg::REG_W-1:0];
            cspt_pkg::REG_OUTSIDE: outside_ff <= pwdata[cspt_pkg::REG_W-1:0];
            cspt_pkg::REG_INSIDE:  inside_ff  <= pwdata[cspt_pkg::REG_W-1:0];
            cspt_pkg::REG_SPACE:   space_ff   <= cspt_pkg::space_type'(pwdata[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         cspt_pkg::REG_LOW:     prdata = {8'h00, low_ff};
         cspt_pkg::REG_HIGH:    prdata = {8'h00, high_ff};
         cspt_pkg::REG_OUTSIDE: prdata = {8'h00, outside_ff};
         cspt_pkg::REG_INSIDE:  prdata = {8'h00, inside_ff};
         cspt_pkg::REG_SPACE:   prdata = {30'h0, space_ff};
         default:               prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- flow control
   // a stage takes new data when it is empty or its own contents move on
   logic [NST-1:0] v_ff, v_in;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = rsp_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < NST; k++) begin
         if (rdy[k]) begin
            v_in[k] = (k == 0) ? req_valid : v_ff[k-1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = rdy[ST_S0];
   assign rsp_valid = v_ff[ST_F2];

   // ------------------------------------------------------- stage 0: input
   cspt_pkg::pixel_type s0_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_S0]) begin
         s0_ff <= req_data;
      end
   end

   // ------------------------------------------------ stage 1: max/min/sector
   s1_type s1_ff, s1_in;

   always_comb begin
      logic [7:0] r, g, b;
      r = s0_ff.red;
      g = s0_ff.green;
      b = s0_ff.blue;
      s1_in.pix = s0_ff;
      s1_in.mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      s1_in.mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      s1_in.sum = 10'(r) + 10'(g) + 10'(b);
      // red wins ties, then green
      if (r >= g && r >= b) begin
         s1_in.sector = cspt_pkg::SEC_RED;
         s1_in.neg    = g < b;
         s1_in.adiff  = (g < b) ? b - g : g - b;
      end else if (g >= b) begin
         s1_in.sector = cspt_pkg::SEC_GREEN;
         s1_in.neg    = b < r;
         s1_in.adiff  = (b < r) ? r - b : b - r;
      end else begin
         s1_in.sector = cspt_pkg::SEC_BLUE;
         s1_in.neg    = r < g;
         s1_in.adiff  = (r < g) ? g - r : r - g;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_S1]) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------- stage 2: divider operands
   s2_type s2_ff, s2_in;

   always_comb begin
      logic [7:0]  chroma;
      logic [19:0] third_prod;
      logic [7:0]  inten;
      logic [8:0]  lsum;
      logic [7:0]  light;
      logic [8:0]  twol;
      logic [8:0]  lum_off;
      logic [7:0]  hsl_den;
      logic [15:0] chroma255;

      chroma     = s1_ff.mx - s1_ff.mn;
      chroma255  = cspt_pkg::mul255(chroma);
      // sum / 3 by reciprocal, exact for sums below 2048
      third_prod = 20'(s1_ff.sum) * 20'(cspt_pkg::THIRD_MUL);
      inten      = third_prod[cspt_pkg::THIRD_SHIFT +: 8];
      lsum       = 9'(s1_ff.mx) + 9'(s1_ff.mn);
      light      = lsum[8:1];
      twol       = {light, 1'b0};
      lum_off    = (twol >= 9'(cspt_pkg::FULL_SCALE)) ? twol - 9'(cspt_pkg::FULL_SCALE)
                                                      : 9'(cspt_pkg::FULL_SCALE) - twol;
      hsl_den    = cspt_pkg::FULL_SCALE - lum_off[7:0];

      s2_in.hue_num       = 16'(s1_ff.adiff) * 16'(cspt_pkg::HUE_STEP);
      s2_in.hue_den       = chroma;
      s2_in.sat_num       = chroma255;
      s2_in.sat_den       = s1_ff.mx;
      s2_in.side.byp0     = s1_ff.pix.red;
      s2_in.side.byp1     = s1_ff.pix.green;
      s2_in.side.c2       = s1_ff.pix.blue;
      s2_in.side.sector   = s1_ff.sector;
      s2_in.side.neg      = s1_ff.neg;
      s2_in.side.grey     = chroma == 8'd0;
      s2_in.side.sat_full = 1'b0;
      s2_in.side.sat_inv  = 1'b0;
      s2_in.side.rgb      = 1'b0;

      case (space_ff)
         cspt_pkg::SPACE_HSV: begin
            s2_in.side.c2 = s1_ff.mx;
         end
         cspt_pkg::SPACE_HSL: begin
            s2_in.side.c2       = light;
            s2_in.sat_den       = hsl_den;
            // quotient would reach 256 or more, or divisor is zero
            s2_in.side.sat_full = chroma255 >= {hsl_den, 8'h00};
         end
         cspt_pkg::SPACE_HSI: begin
            s2_in.side.c2       = inten;
            s2_in.sat_num       = cspt_pkg::mul255(s1_ff.mn);
            s2_in.sat_den       = inten;
            s2_in.side.sat_inv  = 1'b1;
            s2_in.side.sat_full = inten == 8'd0;
         end
         default: begin
            s2_in.side.rgb = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_S2]) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------- divider stages (hue, sat)
   logic [QW-1:0] div_en;
   logic [QW-1:0] hue_q, sat_q;
   side_type      side_ff [QW];

   assign div_en = rdy[ST_DIV +: QW];

   cspt_divider #(
      .NUM_W(cspt_pkg::DIV_NUM_W),
      .DEN_W(cspt_pkg::DIV_DEN_W),
      .QUO_W(QW)
   ) u_hue_div (
      .clock  (clock),
      .step_en(div_en),
      .num    (s2_ff.hue_num),
      .den    (s2_ff.hue_den),
      .quo    (hue_q)
   );

   cspt_divider #(
      .NUM_W(cspt_pkg::DIV_NUM_W),
      .DEN_W(cspt_pkg::DIV_DEN_W),
      .QUO_W(QW)
   ) u_sat_div (
      .clock  (clock),
      .step_en(div_en),
      .num    (s2_ff.sat_num),
      .den    (s2_ff.sat_den),
      .quo    (sat_q)
   );

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         if (div_en[j]) begin
            side_ff[j] <= (j == 0) ? s2_ff.side : side_ff[j-1];
         end
      end
   end

   // ------------------------------------- stage f1: hue and saturation out
   f1_type   f1_ff, f1_in;
   side_type sd;

   assign sd = side_ff[QW-1];

   always_comb begin
      logic [7:0] hue, sat;
      case (sd.sector)
         cspt_pkg::SEC_RED:   hue = (sd.neg && hue_q != 8'd0) ? cspt_pkg::FULL_SCALE - hue_q
                                                               : hue_q;
         cspt_pkg::SEC_GREEN: hue = sd.neg ? cspt_pkg::HUE_GREEN - hue_q
                                           : cspt_pkg::HUE_GREEN + hue_q;
         cspt_pkg::SEC_BLUE:  hue = sd.neg ? cspt_pkg::HUE_BLUE - hue_q
                                           : cspt_pkg::HUE_BLUE + hue_q;
         default:             hue = 8'd0;
      endcase
      if (sd.sat_full) begin
         sat = cspt_pkg::FULL_SCALE;
      end else if (sd.sat_inv) begin
         sat = cspt_pkg::FULL_SCALE - sat_q;
      end else begin
         sat = sat_q;
      end
      // grey pixels carry no hue or saturation
      if (sd.grey) begin
         hue = 8'd0;
         sat = 8'd0;
      end
      if (sd.rgb) begin
         f1_in.c0 = sd.byp0;
         f1_in.c1 = sd.byp1;
      end else begin
         f1_in.c0 = hue;
         f1_in.c1 = sat;
      end
      f1_in.c2 = sd.c2;
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_F1]) begin
         f1_ff <= f1_in;
      end
   end

   // -------------------------------- stage f2: bound check, color select
   cspt_pkg::result_type out_ff, out_in;

   always_comb begin
      logic [7:0] l0, h0, l1, h1, l2, h2;
      logic       hue_ok, ok;
      logic [cspt_pkg::REG_W-1:0] col;
      l0 = low_ff[7:0];
      h0 = high_ff[7:0];
      l1 = low_ff[15:8];
      h1 = high_ff[15:8];
      l2 = low_ff[23:16];
      h2 = high_ff[23:16];
      // channel 0 window wraps around the hue circle when low >= high
      if (l0 < h0) begin
         hue_ok = f1_ff.c0 >= l0 && f1_ff.c0 <= h0;
      end else begin
         hue_ok = f1_ff.c0 >= l0 || f1_ff.c0 <= h0;
      end
      ok = hue_ok && f1_ff.c1 >= l1 && f1_ff.c1 <= h1 && f1_ff.c2 >= l2 && f1_ff.c2 <= h2;
      col = ok ? inside_ff : outside_ff;
      out_in.out_red   = col[7:0];
      out_in.out_green = col[15:8];
      out_in.out_blue  = col[23:16];
      out_in.in_range  = ok;
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_F2]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

// File: hw/rtl/cspt_assert.sv
// port-level checks for the color space pixel threshold, bound to the top level
`include "color_space_pixel_threshold_defines.svh"

module cspt_assert (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cspt_pkg::result_type rsp_data,
   input logic                 pready
);

   // nothing comes out in the cycle after reset
   `CSPT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // an empty output stage means the whole pipeline can move
   `CSPT_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready)

   // a held result keeps its value
   `CSPT_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // register port never waits
   `CSPT_ASSERT_ALWAYS(a_pready, clock, pready)

endmodule

bind color_space_pixel_threshold cspt_assert u_cspt_assert (.*);
